// File: rtl/core/per_key_count_or_time_sampler_defines.svh
// Assertion macros shared by the sampler RTL.
// Included by the top level; relies on nothing else.
`ifndef PER_KEY_COUNT_OR_TIME_SAMPLER_DEFINES_SVH
`define PER_KEY_COUNT_OR_TIME_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKCTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pkcts: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PKCTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pkcts: next-cycle check failed");

`endif

// File: rtl/core/pkcts_pkg.sv
// Shared types and constants of the per-key count/time sampler.
// No dependencies; the interfaces, the sequencer, the top level and the bench import it.
`timescale 1ns / 1ps

package pkcts_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

    localparam int PID_W   = 22;
    localparam int HOOK_W  = 8;
    localparam int KEY_W   = PID_W + HOOK_W;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(1000);
    localparam logic [TIME_W-1:0]  INTERVAL_RESET  = TIME_W'(1000000);

    typedef enum logic [1:0] {
        ACT_FIRST  = 2'd0,
        ACT_MERGED = 2'd1,
        ACT_REPORT = 2'd2,
        ACT_FULL   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_THRESHOLD = 1'b0,
        CFG_REPORT_INTERVAL = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EVAL,
        ST_MISS,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] count_threshold;
        logic [TIME_W-1:0]  report_interval;
    } t_cfg;

    typedef struct packed {
        logic [PID_W-1:0]  process_id;
        logic [HOOK_W-1:0] hook_id;
        logic [TIME_W-1:0] timestamp;
    } t_event;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_time;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_action            action;
        logic [COUNT_W-1:0] report_count;
        logic [PID_W-1:0]   report_process;
        logic [HOOK_W-1:0]  report_hook;
    } t_result;

    typedef struct packed {
        logic              busy;
        logic [FILL_W-1:0] fill;
    } t_ctrl_stat;

endpackage

// File: rtl/core/pkcts_in_if.sv
// Event channel: valid/ready handshake with the event fields.
// Depends on pkcts_pkg.
`timescale 1ns / 1ps

interface pkcts_in_if;
    import pkcts_pkg::*;

    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  process_id;
    logic [HOOK_W-1:0] hook_id;
    logic [TIME_W-1:0] timestamp;

    modport source (output valid, output process_id, output hook_id, output timestamp,
                    input ready);
    modport sink   (input valid, input process_id, input hook_id, input timestamp,
                    output ready);
endinterface

// File: rtl/core/pkcts_out_if.sv
// Result channel: valid/ready handshake with the result fields.
// Depends on pkcts_pkg.
`timescale 1ns / 1ps

interface pkcts_out_if;
    import pkcts_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [COUNT_W-1:0] report_count;
    logic [PID_W-1:0]   report_process;
    logic [HOOK_W-1:0]  report_hook;

    modport source (output valid, output action, output report_count,
                    output report_process, output report_hook, input ready);
    modport sink   (input valid, input action, input report_count,
                    input report_process, input report_hook, output ready);
endinterface

// File: rtl/core/pkcts_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pkcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/core/pkcts_ctrl.sv
// Scan/update sequencer: searches the entry table one entry per cycle, then
// updates or inserts the entry (or finds the table full) and forms the result. Depends on pkcts_pkg.
`timescale 1ns / 1ps

module pkcts_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pkcts_pkg::t_cfg             i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pkcts_pkg::t_event           i_evt,
    output logic [pkcts_pkg::TBL_AW-1:0] o_mem_rd_addr,
    input  pkcts_pkg::t_entry           i_mem_rd_data,
    output logic                        o_mem_we,
    output logic [pkcts_pkg::TBL_AW-1:0] o_mem_wr_addr,
    output pkcts_pkg::t_entry           o_mem_wr_data,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output pkcts_pkg::t_result          o_res,
    output pkcts_pkg::t_ctrl_stat       o_stat
);
    import pkcts_pkg::*;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill;
    logic                r_pend;
    logic [FILL_W-1:0]   r_ridx;
    logic [TBL_AW-1:0]   r_cidx;
    logic [TBL_AW-1:0]   r_hidx;
    t_event              r_evt;
    logic [COUNT_W-1:0]  r_hcount;
    logic [TIME_W-1:0]   r_htime;
    logic [COUNT_W-1:0]  r_ncount;
    logic [TIME_W-1:0]   r_elapsed;
    t_result             r_res;

    logic [KEY_W-1:0]    evt_key;
    logic                issue;
    logic                hit_now;
    logic                has_room;
    logic                do_report;

    // Entries fill lowest-first and are never freed, so [0, fill) are the valid ones.
    assign evt_key   = {r_evt.process_id, r_evt.hook_id};
    assign issue     = (r_ridx < r_fill);
    assign hit_now   = r_pend && (i_mem_rd_data.key == evt_key);
    assign has_room  = (r_fill < FILL_W'(TABLE_ENTRIES));
    assign do_report = (r_ncount >= i_cfg.count_threshold)
                    || (r_elapsed >= i_cfg.report_interval);

    assign o_mem_rd_addr = r_ridx[TBL_AW-1:0];
    assign o_res         = r_res;
    assign o_stat        = '{busy: (r_state != ST_IDLE), fill: r_fill};

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        o_mem_we      = 1'b0;
        o_mem_wr_addr = r_hidx;
        o_mem_wr_data = '{key: evt_key, count: COUNT_ONE, last_time: r_evt.timestamp};
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit_now) begin
                    n_state = ST_CALC;
                end else if (!r_pend && !issue) begin
                    n_state = ST_MISS;
                end
            end
            ST_CALC: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_mem_we = 1'b1;
                if (!do_report) begin
                    o_mem_wr_data.count     = r_ncount;
                    o_mem_wr_data.last_time = r_htime;
                end
                n_state = ST_OUT;
            end
            ST_MISS: begin
                o_mem_we      = has_room;
                o_mem_wr_addr = r_fill[TBL_AW-1:0];
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_pend <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_pend <= issue;
            end
            if (r_state == ST_MISS && has_room) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_evt  <= i_evt;
                r_ridx <= '0;
            end
            ST_SCAN: begin
                r_cidx <= r_ridx[TBL_AW-1:0];
                if (issue) begin
                    r_ridx <= r_ridx + FILL_W'(1);
                end
                if (hit_now) begin
                    r_hidx   <= r_cidx;
                    r_hcount <= i_mem_rd_data.count;
                    r_htime  <= i_mem_rd_data.last_time;
                end
            end
            ST_CALC: begin
                // Saturate the count at its ceiling; elapsed wraps modulo 2^32.
                r_ncount  <= (r_hcount == COUNT_MAX) ? COUNT_MAX : r_hcount + COUNT_ONE;
                r_elapsed <= r_evt.timestamp - r_htime;
            end
            ST_EVAL: begin
                r_res.action         <= do_report ? ACT_REPORT : ACT_MERGED;
                r_res.report_count   <= do_report ? r_ncount : '0;
                r_res.report_process <= r_evt.process_id;
                r_res.report_hook    <= r_evt.hook_id;
            end
            ST_MISS: begin
                r_res.action         <= has_room ? ACT_FIRST : ACT_FULL;
                r_res.report_count   <= '0;
                r_res.report_process <= r_evt.process_id;
                r_res.report_hook    <= r_evt.hook_id;
            end
            default: begin
            end
        endcase
    end
endmodule

// File: rtl/core/per_key_count_or_time_sampler.sv
// Per-key count/time sampler, top level.
// Channels: i_evt (sink) takes one event beat: process_id, hook_id, timestamp.
//   o_res (source) gives exactly one result beat per event: action,
//   report_count, report_process, report_hook.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 count
//   threshold, 1 report interval); write only while no event is in flight.
// Flow: an event scans the N occupied entries of the 256-entry table one per
//   cycle out of the entry RAM (one read port, registered read); then the
//   sequencer forms the new count and elapsed time, writes the entry back
//   (or inserts a new one if there is room) and loads the result. It holds
//   one event at a time and takes the next one the cycle after its result
//   moves on.
// Stall: the result sits in an output register; while it waits the next
//   event is accepted and scanned, and the sequencer holds its finished
//   result until the output register frees up.
// Reset: synchronous, active low; empties the table (fill count to zero,
//   no clearing pass), restores threshold 1000 and interval 1000000.
// Depends on pkcts_pkg, pkcts_in_if, pkcts_out_if, pkcts_ram, pkcts_ctrl.
`timescale 1ns / 1ps
`include "per_key_count_or_time_sampler_defines.svh"

module per_key_count_or_time_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pkcts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pkcts_pkg::CFG_W-1:0]     i_cfg_data,
    pkcts_in_if.sink                       i_evt,
    pkcts_out_if.source                    o_res
);
    import pkcts_pkg::*;

    t_cfg        r_cfg;
    logic        r_out_valid;
    t_result     r_out;

    t_event      evt;
    t_result     ctrl_res;
    logic        ctrl_res_valid;
    logic        res_ready;
    t_ctrl_stat  ctrl_stat;

    logic [TBL_AW-1:0]  mem_rd_addr;
    logic [TBL_AW-1:0]  mem_wr_addr;
    logic               mem_we;
    t_entry             mem_wr_data;
    logic [ENTRY_W-1:0] mem_rd_bits;
    t_entry             mem_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_threshold <= THRESHOLD_RESET;
            r_cfg.report_interval <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_COUNT_THRESHOLD: r_cfg.count_threshold <= i_cfg_data[COUNT_W-1:0];
                CFG_REPORT_INTERVAL: r_cfg.report_interval <= i_cfg_data[TIME_W-1:0];
            endcase
        end
    end

    assign evt = '{process_id: i_evt.process_id, hook_id: i_evt.hook_id,
                   timestamp: i_evt.timestamp};

    pkcts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (TBL_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (ENTRY_W'(mem_wr_data)),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_bits)
    );

    assign mem_rd_data = t_entry'(mem_rd_bits);

    pkcts_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_evt.valid),
        .o_in_ready    (i_evt.ready),
        .i_evt         (evt),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_we      (mem_we),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_res_valid   (ctrl_res_valid),
        .i_res_ready   (res_ready),
        .o_res         (ctrl_res),
        .o_stat        (ctrl_stat)
    );

    // Load a new beat when the register is empty or drains this cycle.
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_res_valid && res_ready) begin
            r_out <= ctrl_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.action         = r_out.action;
    assign o_res.report_count   = r_out.report_count;
    assign o_res.report_process = r_out.report_process;
    assign o_res.report_hook    = r_out.report_hook;

    `PKCTS_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, ctrl_stat.fill <= FILL_W'(TABLE_ENTRIES))
    `PKCTS_ASSERT_IMPL(a_count_only_on_report, i_clk, i_rst_n, r_out_valid && r_out.action != ACT_REPORT, r_out.report_count == '0)
    `PKCTS_ASSERT_IMPL(a_report_nonzero, i_clk, i_rst_n, r_out_valid && r_out.action == ACT_REPORT, r_out.report_count != '0)
    `PKCTS_ASSERT_NEXT(a_handoff_lands, i_clk, i_rst_n, ctrl_res_valid && res_ready, r_out_valid && !ctrl_res_valid)

endmodule

// File: tb/per_key_count_or_time_sampler_tb.sv
// Self-checking bench for the per-key count/time sampler: directed and random events,
// with a per-key table tracker that predicts each result beat.
// Depends on pkcts_pkg, pkcts_in_if, pkcts_out_if and the sampler RTL.
`timescale 1ns / 1ps

module per_key_count_or_time_sampler_tb;
    import pkcts_pkg::*;

    localparam int POOL_SIZE   = 24;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_CYCLES = 2000;

    // Tracks the key table and the registers; predicts one result per event.
    class sampler_scoreboard;
        logic               slot_used  [TABLE_ENTRIES];
        logic [KEY_W-1:0]   slot_key   [TABLE_ENTRIES];
        logic [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
        logic [TIME_W-1:0]  slot_time  [TABLE_ENTRIES];
        logic [COUNT_W-1:0] threshold;
        logic [TIME_W-1:0]  interval;
        t_result            expected_results[$];
        int                 used_slots;
        int                 mismatches;
        int                 action_tally[4];

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
            end
            foreach (action_tally[i]) begin
                action_tally[i] = 0;
            end
            threshold  = THRESHOLD_RESET;
            interval   = INTERVAL_RESET;
            used_slots = 0;
            mismatches = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_COUNT_THRESHOLD: threshold = data[COUNT_W-1:0];
                CFG_REPORT_INTERVAL: interval  = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_event(logic [PID_W-1:0] pid, logic [HOOK_W-1:0] hook,
                                 logic [TIME_W-1:0] now);
            logic [KEY_W-1:0]   key;
            logic [COUNT_W:0]   next_count;
            logic [TIME_W-1:0]  elapsed;
            int                 hit;
            int                 free_slot;
            t_result            res;
            key       = {pid, hook};
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_used[i]) begin
                    if (hit < 0 && slot_key[i] == key) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            res.report_count   = '0;
            res.report_process = pid;
            res.report_hook    = hook;
            if (hit >= 0) begin
                next_count = {1'b0, slot_count[hit]} + 1'b1;
                if (next_count > {1'b0, COUNT_MAX}) next_count = {1'b0, COUNT_MAX};
                // wrapping tick difference: a step back reads as a long wait
                elapsed = now - slot_time[hit];
                if (next_count[COUNT_W-1:0] >= threshold || elapsed >= interval) begin
                    res.action       = ACT_REPORT;
                    res.report_count = next_count[COUNT_W-1:0];
                    slot_count[hit]  = COUNT_ONE;
                    slot_time[hit]   = now;
                end else begin
                    res.action      = ACT_MERGED;
                    slot_count[hit] = next_count[COUNT_W-1:0];
                end
            end else if (free_slot >= 0) begin
                res.action            = ACT_FIRST;
                slot_used[free_slot]  = 1'b1;
                slot_key[free_slot]   = key;
                slot_count[free_slot] = COUNT_ONE;
                slot_time[free_slot]  = now;
                used_slots++;
            end else begin
                res.action = ACT_FULL;
            end
            action_tally[int'(res.action)]++;
            expected_results.push_back(res);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("[%0t] %s", $time, what);
        endfunction

        function void check_result(logic [1:0] act, logic [COUNT_W-1:0] cnt,
                                   logic [PID_W-1:0] pid, logic [HOOK_W-1:0] hook);
            t_result want;
            if (expected_results.size() == 0) begin
                flag($sformatf("result beat with nothing pending: act %0d cnt %0d pid %h hook %h",
                               act, cnt, pid, hook));
                return;
            end
            want = expected_results.pop_front();
            if (want.action !== act || want.report_count !== cnt ||
                want.report_process !== pid || want.report_hook !== hook) begin
                flag($sformatf("exp act %0d cnt %0d pid %h hook %h, got act %0d cnt %0d pid %h hook %h",
                               want.action, want.report_count, want.report_process,
                               want.report_hook, act, cnt, pid, hook));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    pkcts_in_if  evt_if ();
    pkcts_out_if res_if ();

    per_key_count_or_time_sampler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt_if),
        .o_res      (res_if)
    );

    sampler_scoreboard  sb = new();
    int                 snd_idle_pct = 0;
    int                 rcv_idle_pct = 0;
    int                 hold_request = 0;
    logic [PID_W-1:0]   pool_pid  [POOL_SIZE];
    logic [HOOK_W-1:0]  pool_hook [POOL_SIZE];
    logic [TIME_W-1:0]  cur_time;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random back-pressure, or one long hold-off on request.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (evt_if.valid && evt_if.ready)
                sb.note_event(evt_if.process_id, evt_if.hook_id, evt_if.timestamp);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.action, res_if.report_count,
                                res_if.report_process, res_if.report_hook);
        end
    end

    task automatic offer_event(input logic [PID_W-1:0] pid, input logic [HOOK_W-1:0] hook,
                               input logic [TIME_W-1:0] ts);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            evt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.process_id <= pid;
        evt_if.hook_id    <= hook;
        evt_if.timestamp  <= ts;
        // hold the beat until it is taken
        do begin
            @(posedge i_clk);
        end while (evt_if.ready !== 1'b1);
    endtask

    task automatic wait_results_drained();
        evt_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_register(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random_events(input int count);
        logic [PID_W-1:0]  pid;
        logic [HOOK_W-1:0] hook;
        int                sel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                sel  = $urandom_range(0, POOL_SIZE - 1);
                pid  = pool_pid[sel];
                hook = pool_hook[sel];
            end else begin
                pid  = PID_W'($urandom);
                hook = HOOK_W'($urandom);
            end
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                cur_time = cur_time + $urandom_range(0, 15);
            end else if (sel < 70) begin
                cur_time = cur_time + sb.interval;
            end else if (sel < 80) begin
                if (sb.interval > 32'h4000_0000) cur_time = cur_time + $urandom;
                else cur_time = cur_time + $urandom_range(0, 2 * sb.interval);
            end else if (sel < 90) begin
                cur_time = cur_time - $urandom_range(1, 1000);
            end else begin
                cur_time = $urandom;
            end
            offer_event(pid, hook, cur_time);
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_COUNT_THRESHOLD;
        i_cfg_data        <= '0;
        evt_if.valid      <= 1'b0;
        evt_if.process_id <= '0;
        evt_if.hook_id    <= '0;
        evt_if.timestamp  <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pid[i]  = PID_W'($urandom);
            pool_hook[i] = HOOK_W'($urandom);
        end
        pool_pid[0]  = '0;
        pool_hook[0] = '0;
        pool_pid[1]  = '1;
        pool_hook[1] = '1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: insert, merge, wrap forward, step back, interval boundary
        offer_event(22'h000000, 8'h00, 32'h0000_0000);
        offer_event(22'h3FFFFF, 8'hFF, 32'hFFFF_FFFF);
        offer_event(22'h000000, 8'h00, 32'd10);
        offer_event(22'h3FFFFF, 8'hFF, 32'd5);
        offer_event(22'h000000, 8'h00, 32'd5);
        offer_event(22'h2AAAAA, 8'h55, 32'd1000);
        offer_event(22'h2AAAAA, 8'h55, 32'd1000999);
        offer_event(22'h2AAAAA, 8'h55, 32'd1001000);
        wait_results_drained();

        // zero threshold, with junk in the unused upper data bits
        write_register(CFG_COUNT_THRESHOLD, 32'hBEEF_0000);
        write_register(CFG_REPORT_INTERVAL, 32'hFFFF_FFFF);
        offer_event(22'h155555, 8'hAA, 32'd7);
        offer_event(22'h155555, 8'hAA, 32'd8);
        offer_event(22'h000000, 8'h00, 32'd9);
        wait_results_drained();

        // zero interval: every hit reports even with no time passing
        write_register(CFG_COUNT_THRESHOLD, 32'h0000_FFFF);
        write_register(CFG_REPORT_INTERVAL, 32'h0000_0000);
        offer_event(22'h3FFFFF, 8'hFF, 32'd100);
        offer_event(22'h3FFFFF, 8'hFF, 32'd100);
        wait_results_drained();

        // count up, then lower the threshold below the stored count
        write_register(CFG_REPORT_INTERVAL, 32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++) offer_event(22'h2AAAAA, 8'h55, 32'd2000 + i);
        wait_results_drained();
        write_register(CFG_COUNT_THRESHOLD, 32'd3);
        offer_event(22'h2AAAAA, 8'h55, 32'd3000);
        wait_results_drained();

        cur_time     = 32'd5000;
        snd_idle_pct = 32;
        rcv_idle_pct = 86;
        write_register(CFG_COUNT_THRESHOLD, 32'd4);
        write_register(CFG_REPORT_INTERVAL, 32'd1000);
        run_random_events(64);
        wait_results_drained();
        write_register(CFG_COUNT_THRESHOLD, 32'h0000_FFFF);
        write_register(CFG_REPORT_INTERVAL, 32'hFFFF_FFFF);
        run_random_events(64);
        wait_results_drained();

        snd_idle_pct = 86;
        rcv_idle_pct = 32;
        write_register(CFG_COUNT_THRESHOLD, 32'd1);
        write_register(CFG_REPORT_INTERVAL, 32'd1);
        run_random_events(64);
        wait_results_drained();
        write_register(CFG_COUNT_THRESHOLD, $urandom_range(2, 20));
        write_register(CFG_REPORT_INTERVAL, $urandom_range(1, 5000));
        run_random_events(64);
        wait_results_drained();

        // no idling; one long result hold-off and one full drain mid-phase
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_register(CFG_COUNT_THRESHOLD, 32'(THRESHOLD_RESET));
        write_register(CFG_REPORT_INTERVAL, INTERVAL_RESET);
        run_random_events(30);
        hold_request = HOLD_CYCLES;
        run_random_events(30);
        wait_results_drained();
        run_random_events(48);
        wait_results_drained();
        write_register(CFG_COUNT_THRESHOLD, {16'($urandom), 16'($urandom_range(1, 65535))});
        write_register(CFG_REPORT_INTERVAL, $urandom);
        run_random_events(64);
        wait_results_drained();

        // fill every slot with fresh keys, then run against a full table
        write_register(CFG_COUNT_THRESHOLD, 32'd8);
        write_register(CFG_REPORT_INTERVAL, 32'd5000);
        while (sb.used_slots < TABLE_ENTRIES) begin
            cur_time = cur_time + $urandom_range(0, 15);
            offer_event(PID_W'($urandom), HOOK_W'($urandom), cur_time);
        end
        for (int i = 0; i < 4; i++) offer_event(PID_W'($urandom), HOOK_W'($urandom), cur_time);
        run_random_events(40);

        wait_results_drained();
        repeat (300) @(posedge i_clk);
        $display("covered %0d events: %0d first-seen, %0d merged, %0d reports, %0d table-full",
                 sb.action_tally[0] + sb.action_tally[1] + sb.action_tally[2] +
                 sb.action_tally[3], sb.action_tally[ACT_FIRST], sb.action_tally[ACT_MERGED],
                 sb.action_tally[ACT_REPORT], sb.action_tally[ACT_FULL]);
        $display("settings swept zero/one/all-ones threshold and interval; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
